[hw/rtl/tlpm_pkg.sv]
// ----------------------------------------------------------------------------
// tlpm_pkg
// shared types and defaults of the trie longest prefix matcher
// ----------------------------------------------------------------------------
package tlpm_pkg;

  localparam int TLPM_ALPHA_LOW      = 33;
  localparam int TLPM_ALPHA_HIGH     = 126;
  localparam int TLPM_MAX_NODES      = 4096;
  localparam int TLPM_MAX_PREFIXES   = 256;
  localparam int TLPM_MAX_PREFIX_LEN = 255;

  localparam int ID_W  = 8;
  localparam int LEN_W = 8;

  typedef enum logic [1:0] {
    MODE_LOAD_CHAR   = 2'd0,
    MODE_END_PREFIX  = 2'd1,
    MODE_LOOKUP_CHAR = 2'd2,
    MODE_END_LOOKUP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NODE_FULL = 2'd1,
    STATUS_PFX_FULL  = 2'd2,
    STATUS_BAD_CHAR  = 2'd3
  } status_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]  pfx_id;
    logic [LEN_W-1:0] prefix_len;
    status_e          status;
  } out_word_t;

  // best prefix seen at a node, with its length
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
  } best_t;

endpackage

[hw/rtl/tlpm_ram.sv]
// ----------------------------------------------------------------------------
// tlpm_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/trie_longest_prefix_match.sv]
// ----------------------------------------------------------------------------
// trie_longest_prefix_match
// path: an end word goes through the result register and S_EMIT into the output
//   register; an end lookup from a node other than the root first reads the best table
// acceptance: a new word is taken only in S_READY, after the child table read whose
//   data addresses the next read; a stalled result holds the next word
// reset: control clears at once, then a sweep zeroes every entry of the child table
// ----------------------------------------------------------------------------
module trie_longest_prefix_match import tlpm_pkg::*; #(
  parameter int ALPHA_LOW      = TLPM_ALPHA_LOW,
  parameter int ALPHA_HIGH     = TLPM_ALPHA_HIGH,
  parameter int MAX_NODES      = TLPM_MAX_NODES,
  parameter int MAX_PREFIXES   = TLPM_MAX_PREFIXES,
  parameter int MAX_PREFIX_LEN = TLPM_MAX_PREFIX_LEN
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int ALPHA_SIZE  = (ALPHA_HIGH >= ALPHA_LOW) ? (ALPHA_HIGH - ALPHA_LOW + 1) : 1;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = NODE_W + 1;
  localparam int CHILD_DEPTH = MAX_NODES * ALPHA_SIZE;
  localparam int ADDR_W      = $clog2(CHILD_DEPTH);
  localparam int PFX_W       = $clog2(MAX_PREFIXES + 1);
  localparam int BEST_W      = $bits(best_t);

  localparam logic [CNT_W-1:0]  NODE_LIMIT = CNT_W'(MAX_NODES);
  localparam logic [PFX_W-1:0]  PFX_LIMIT  = PFX_W'(MAX_PREFIXES);
  localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(MAX_PREFIX_LEN);
  localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(CHILD_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_READY,
    S_LOAD_CHILD,
    S_LOAD_BEST,
    S_LOOK_CHILD,
    S_LOOK_BEST,
    S_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [ADDR_W-1:0]   slot_q, slot_d;
  logic [NODE_W-1:0]   cursor_q, cursor_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic                stopped_q, stopped_d;
  status_e             fault_q, fault_d;
  logic [CNT_W-1:0]    nodes_q, nodes_d;
  logic [PFX_W-1:0]    prefixes_q, prefixes_d;
  best_t               par_best_q, par_best_d;
  out_word_t           res_q, res_d;
  out_word_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                in_acc;
  logic                in_alpha;
  logic [ADDR_W-1:0]   slot;
  best_t               par_best;

  logic                c_we, c_re;
  logic [ADDR_W-1:0]   c_waddr;
  logic [NODE_W-1:0]   c_wdata, c_rdata;
  logic                b_we, b_re;
  logic [NODE_W-1:0]   b_waddr, b_raddr;
  best_t               b_wdata, b_rdata;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_alpha = (in_word_i.char_code >= 8'(ALPHA_LOW)) &&
                    (in_word_i.char_code <= 8'(ALPHA_HIGH));
  assign slot     = ADDR_W'(cursor_q) * ADDR_W'(ALPHA_SIZE) +
                    ADDR_W'(in_word_i.char_code - 8'(ALPHA_LOW));
  assign par_best = (cursor_q == '0) ? best_t'('0) : b_rdata;
  assign c_re     = (state_q == S_READY);

  tlpm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (CHILD_DEPTH)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (slot),
    .rdata_o (c_rdata)
  );

  tlpm_ram #(
    .WIDTH (BEST_W),
    .DEPTH (MAX_NODES)
  ) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    slot_d      = slot_q;
    cursor_d    = cursor_q;
    len_d       = len_q;
    stopped_d   = stopped_q;
    fault_d     = fault_q;
    nodes_d     = nodes_q;
    prefixes_d  = prefixes_q;
    par_best_d  = par_best_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    c_we        = 1'b0;
    c_waddr     = slot_q;
    c_wdata     = '0;
    b_we        = 1'b0;
    b_waddr     = cursor_q;
    b_wdata     = par_best_q;
    b_re        = 1'b0;
    b_raddr     = cursor_q;

    unique case (state_q)
      S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_q;
        clr_d   = clr_q + ADDR_W'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_READY;
        end
      end

      S_READY: begin
        if (in_acc) begin
          unique case (in_word_i.mode)
            MODE_LOAD_CHAR: begin
              if (fault_q == STATUS_OK) begin
                if (!in_alpha || len_q >= LEN_LIMIT) begin
                  fault_d = STATUS_BAD_CHAR;
                end else begin
                  slot_d  = slot;
                  b_re    = 1'b1;
                  state_d = S_LOAD_CHILD;
                end
              end
            end

            MODE_END_PREFIX: begin
              if (fault_q != STATUS_OK) begin
                res_d = '{pfx_id: '0, prefix_len: len_q, status: fault_q};
              end else if (len_q == '0) begin
                res_d = '{pfx_id: '0, prefix_len: '0, status: STATUS_OK};
              end else if (prefixes_q >= PFX_LIMIT) begin
                res_d = '{pfx_id: '0, prefix_len: len_q, status: STATUS_PFX_FULL};
              end else begin
                b_we       = 1'b1;
                b_wdata    = '{id: ID_W'(prefixes_q), len: len_q};
                prefixes_d = prefixes_q + PFX_W'(1);
                res_d      = '{pfx_id: ID_W'(prefixes_q), prefix_len: len_q,
                               status: STATUS_OK};
              end
              cursor_d  = '0;
              len_d     = '0;
              stopped_d = 1'b0;
              fault_d   = STATUS_OK;
              state_d   = S_EMIT;
            end

            MODE_LOOKUP_CHAR: begin
              if (!stopped_q) begin
                if (!in_alpha) begin
                  stopped_d = 1'b1;
                end else begin
                  state_d = S_LOOK_CHILD;
                end
              end
            end

            MODE_END_LOOKUP: begin
              if (cursor_q == '0) begin
                res_d   = '{pfx_id: '0, prefix_len: '0, status: STATUS_OK};
                state_d = S_EMIT;
              end else begin
                b_re    = 1'b1;
                state_d = S_LOOK_BEST;
              end
              cursor_d  = '0;
              len_d     = '0;
              stopped_d = 1'b0;
              fault_d   = STATUS_OK;
            end

            default: ;
          endcase
        end
      end

      S_LOAD_CHILD: begin
        par_best_d = par_best;
        state_d    = S_READY;
        if (c_rdata == '0) begin
          if (nodes_q >= NODE_LIMIT) begin
            fault_d = STATUS_NODE_FULL;
          end else begin
            c_we     = 1'b1;
            c_wdata  = nodes_q[NODE_W-1:0];
            b_we     = 1'b1;
            b_waddr  = nodes_q[NODE_W-1:0];
            b_wdata  = par_best;
            cursor_d = nodes_q[NODE_W-1:0];
            nodes_d  = nodes_q + CNT_W'(1);
            len_d    = len_q + LEN_W'(1);
          end
        end else begin
          b_re     = 1'b1;
          b_raddr  = c_rdata;
          cursor_d = c_rdata;
          len_d    = len_q + LEN_W'(1);
          state_d  = S_LOAD_BEST;
        end
      end

      S_LOAD_BEST: begin
        // node with no prefix of its own inherits the parent's best
        if (b_rdata.id == '0) begin
          b_we = 1'b1;
        end
        state_d = S_READY;
      end

      S_LOOK_CHILD: begin
        if (c_rdata == '0) begin
          stopped_d = 1'b1;
        end else begin
          cursor_d = c_rdata;
          if (len_q != '1) begin
            len_d = len_q + LEN_W'(1);
          end
        end
        state_d = S_READY;
      end

      S_LOOK_BEST: begin
        res_d   = '{pfx_id: b_rdata.id, prefix_len: b_rdata.len, status: STATUS_OK};
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_READY;
        end
      end

      default: state_d = S_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      slot_q      <= '0;
      cursor_q    <= '0;
      len_q       <= '0;
      stopped_q   <= 1'b0;
      fault_q     <= STATUS_OK;
      nodes_q     <= CNT_W'(1);
      prefixes_q  <= PFX_W'(1);
      par_best_q  <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      slot_q      <= slot_d;
      cursor_q    <= cursor_d;
      len_q       <= len_d;
      stopped_q   <= stopped_d;
      fault_q     <= fault_d;
      nodes_q     <= nodes_d;
      prefixes_q  <= prefixes_d;
      par_best_q  <= par_best_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_READY);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[hw/rtl/tlpm_checker.sv]
// ----------------------------------------------------------------------------
// tlpm_checker
// port level checks of the trie longest prefix matcher
// ----------------------------------------------------------------------------
module tlpm_checker import tlpm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("stalled output word changed");

  a_fault_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != STATUS_OK |-> out_word_o.pfx_id == '0)
    else $error("faulted word carries a prefix id");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == STATUS_OK && out_word_o.pfx_id == '0
    |-> out_word_o.prefix_len == '0)
    else $error("empty prefix with nonzero length");

endmodule

bind trie_longest_prefix_match tlpm_checker u_tlpm_checker (.*);
